// ===== src/pid_event_dedup_filter_macros.svh =====
//------------------------------------------------------------------------------
// pid_event_dedup_filter_macros
// Assertion macros used by the checker of the event dedup filter.
//------------------------------------------------------------------------------
`ifndef PID_EVENT_DEDUP_FILTER_MACROS_SVH
`define PID_EVENT_DEDUP_FILTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PEDF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define PEDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pedf_pkg.sv =====
//------------------------------------------------------------------------------
// pedf_pkg
// Types and constants of the process event dedup filter.
//------------------------------------------------------------------------------
package pedf_pkg;

    // Table depth; a power of two so the bucket index is the low id bits.
    localparam int BUCKET_COUNT = 2048;
    localparam int IDX_W        = $clog2(BUCKET_COUNT);

    localparam int ID_W     = 32;
    localparam int TIME_W   = 32;
    localparam int CAP_W    = 8;
    localparam int MASK_W   = 64;
    localparam int BIT_W    = $clog2(MASK_W);
    localparam int WINDOW_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(60);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = WINDOW_W;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(1);

    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [TIME_W-1:0] start;
        logic [MASK_W-1:0] mask;
    } t_bucket;

    localparam int BUCKET_W = $bits(t_bucket);

    // Outcome of one bucket lookup.
    typedef struct packed {
        logic    suppress;
        logic    write_en;
        t_bucket bucket;
    } t_upd_res;

endpackage

// ===== src/pedf_bucket_ram.sv =====
//------------------------------------------------------------------------------
// pedf_bucket_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
//------------------------------------------------------------------------------
module pedf_bucket_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pedf_bucket_upd.sv =====
//------------------------------------------------------------------------------
// pedf_bucket_upd
// Rebind, expiry and seen-mask update for one bucket read from the table.
//------------------------------------------------------------------------------
module pedf_bucket_upd
    import pedf_pkg::*;
(
    input  t_bucket             i_bucket,
    input  logic [ID_W-1:0]     i_proc_id,
    input  logic [BIT_W-1:0]    i_cap,
    input  logic [TIME_W-1:0]   i_now_sec,
    input  logic [WINDOW_W-1:0] i_window,
    output t_upd_res            o_res
);

    logic [TIME_W-1:0] age;
    logic              expired;
    logic              rebind;
    t_bucket           base;
    logic [MASK_W-1:0] cap_bit;

    always_comb begin
        age     = i_now_sec - i_bucket.start;
        // A start time of zero marks a window that never expires by time.
        expired = (i_bucket.start != '0) &&
                  (age >= {{(TIME_W-WINDOW_W){1'b0}}, i_window});
        rebind  = (i_bucket.owner != i_proc_id) || expired;

        if (rebind) begin
            base.owner = i_proc_id;
            base.start = i_now_sec;
            base.mask  = '0;
        end else begin
            base = i_bucket;
        end

        cap_bit = MASK_W'(1) << i_cap;

        o_res.suppress    = |(base.mask & cap_bit);
        // A suppressed event leaves the bucket as it was.
        o_res.write_en    = !o_res.suppress;
        o_res.bucket      = base;
        o_res.bucket.mask = base.mask | cap_bit;
    end

endmodule

// ===== src/pid_event_dedup_filter.sv =====
//------------------------------------------------------------------------------
// pid_event_dedup_filter
// Time-window dedup of (process id, capability) events over a direct-mapped
// bucket table held in one synchronous RAM.
//
// Channel   Direction  Handshake             Payload
// event     in         start, busy           i_proc_id i_cap_index i_now_sec
//                                            i_time_valid
// result    out        o_done (strobe)       o_suppress
// config    in         i_cfg_we              i_cfg_idx i_cfg_data
//
// For each event the bucket read is issued at the accept edge, and the next
// cycle updates the bucket and writes it back. The result strobe follows in
// the cycle after that, when busy is low again and the next event can be
// taken. busy stays high in the update cycle, so a following event always
// reads the bucket after its write-back. After reset a clearing pass writes
// all BUCKET_COUNT entries with busy high; configuration writes are taken at
// any time.
// The result strobe lasts one cycle and cannot be stalled.
//------------------------------------------------------------------------------
module pid_event_dedup_filter
    import pedf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ID_W-1:0]       i_proc_id,
    input  logic [CAP_W-1:0]      i_cap_index,
    input  logic [TIME_W-1:0]     i_now_sec,
    input  logic                  i_time_valid,
    output logic                  o_done,
    output logic                  o_suppress,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state              r_state;
    logic                r_busy;
    logic                r_done;
    logic                r_suppress;
    logic [IDX_W-1:0]    r_clr_addr;

    logic [WINDOW_W-1:0] r_window;
    logic                r_enable;

    logic [ID_W-1:0]     r_pid;
    logic [BIT_W-1:0]    r_cap;
    logic [TIME_W-1:0]   r_now;
    logic                r_bypass;

    logic                accept;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_bucket             ram_wdata;
    t_bucket             ram_rdata;
    t_upd_res            upd;

    assign accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW: r_window <= i_cfg_data;
                REG_ENABLE: r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pid    <= i_proc_id;
            r_cap    <= i_cap_index[BIT_W-1:0];
            r_now    <= i_now_sec;
            r_bypass <= !r_enable || !i_time_valid || (i_cap_index[CAP_W-1:BIT_W] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_busy     <= 1'b1;
            r_done     <= 1'b0;
            r_suppress <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_done     <= 1'b0;
            r_suppress <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + IDX_W'(1);
                    if (r_clr_addr == IDX_W'(BUCKET_COUNT - 1)) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_LOOK;
                        r_busy  <= 1'b1;
                    end
                end
                S_LOOK: begin
                    r_state    <= S_IDLE;
                    r_busy     <= 1'b0;
                    r_done     <= 1'b1;
                    r_suppress <= !r_bypass && upd.suppress;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_LOOK) && !r_bypass && upd.write_en;
            ram_waddr = r_pid[IDX_W-1:0];
            ram_wdata = upd.bucket;
        end
    end

    pedf_bucket_ram #(
        .WIDTH (BUCKET_W),
        .DEPTH (BUCKET_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_proc_id[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    pedf_bucket_upd u_upd (
        .i_bucket  (ram_rdata),
        .i_proc_id (r_pid),
        .i_cap     (r_cap),
        .i_now_sec (r_now),
        .i_window  (r_window),
        .o_res     (upd)
    );

    assign busy       = r_busy;
    assign o_done     = r_done;
    assign o_suppress = r_suppress;

endmodule

// ===== src/pedf_checker.sv =====
//------------------------------------------------------------------------------
// pedf_checker
// Port-level checks of the event dedup filter, bound to the top level.
//------------------------------------------------------------------------------
`include "pid_event_dedup_filter_macros.svh"

module pedf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_suppress
);

    // An accepted event holds the block off for the following cycle.
    `PEDF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after accepted beat")

    // Every accepted event gives a result beat after its update cycle.
    `PEDF_ASSERT_NEXT(a_accept_done, start && !busy, ##1 o_done, "result beat missing")

    // Result strobes never come back to back.
    `PEDF_ASSERT_NEXT(a_done_gap, o_done, !o_done, "result beats back to back")

    // The result beat coincides with the block being ready again.
    `PEDF_ASSERT_SAME(a_done_idle, o_done, !busy, "result beat while busy")

    `PEDF_ASSERT_SAME(a_supp_done, o_suppress, o_done, "suppress outside result beat")

endmodule

bind pid_event_dedup_filter pedf_checker u_pedf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_done     (o_done),
    .o_suppress (o_suppress)
);

// ===== sim/tb_pid_event_dedup_filter.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_pid_event_dedup_filter
// Self-checking bench for the event dedup filter. Events are sent on the
// start/busy port, and a mirror of the bucket table predicts each suppress
// bit. A directed set comes first: the table edges, window wraparound,
// backwards time, the bypass cases, zero start times and a zero window. Then
// random phases run under different window settings and sender idle rates.
//------------------------------------------------------------------------------
module tb_pid_event_dedup_filter;
    import pedf_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PIDS     = 12;
    localparam int NUM_PHASES   = 6;

    localparam int PH_WINDOW [NUM_PHASES] = '{60, 1, 65535, 7, 300, 20};
    localparam int PH_ENABLE [NUM_PHASES] = '{1, 1, 1, 0, 1, 1};
    localparam int PH_IDLE   [NUM_PHASES] = '{0, 76, 34, 0, 76, 34};
    localparam int PH_ITEMS  [NUM_PHASES] = '{400, 250, 300, 150, 250, 300};

    // Mirror of the bucket table and store of the suppress bits still owed.
    class dedup_scoreboard;
        bit [ID_W-1:0]     owner_tbl [BUCKET_COUNT];
        bit [TIME_W-1:0]   start_tbl [BUCKET_COUNT];
        bit [MASK_W-1:0]   seen_tbl  [BUCKET_COUNT];
        bit [WINDOW_W-1:0] window_sec;
        bit                filter_on;
        bit                expected_suppress [$];
        int                mismatch_count;

        function new();
            window_sec     = WINDOW_RESET;
            filter_on      = 1'b1;
            mismatch_count = 0;
        endfunction

        function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            if (idx == REG_WINDOW) begin
                window_sec = data;
            end else if (idx == REG_ENABLE) begin
                filter_on = data[0];
            end
        endfunction

        function void note_event(bit [ID_W-1:0] pid, bit [CAP_W-1:0] cap,
                                 bit [TIME_W-1:0] now, bit tv);
            bit [IDX_W-1:0]  slot;
            bit [TIME_W-1:0] age;
            bit              verdict;
            verdict = 1'b0;
            if (filter_on && tv && cap < MASK_W) begin
                slot = pid[IDX_W-1:0];
                age  = now - start_tbl[slot];
                // A zero start time never expires; only a new owner rebinds it.
                if (owner_tbl[slot] != pid ||
                    (start_tbl[slot] != '0 && age >= TIME_W'(window_sec))) begin
                    owner_tbl[slot] = pid;
                    start_tbl[slot] = now;
                    seen_tbl[slot]  = '0;
                end
                if (seen_tbl[slot][cap[BIT_W-1:0]]) begin
                    verdict = 1'b1;
                end else begin
                    seen_tbl[slot][cap[BIT_W-1:0]] = 1'b1;
                end
            end
            expected_suppress.push_back(verdict);
        endfunction

        task report_mismatch(string msg);
            $display("%0t: MISMATCH %s", $time, msg);
            mismatch_count++;
        endtask

        task check_suppress(bit got);
            bit want;
            if (expected_suppress.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected, suppress=%0b", got));
            end else begin
                want = expected_suppress.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("suppress got %0b want %0b", got, want));
                end
            end
        endtask
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic [ID_W-1:0]       i_proc_id    = '0;
    logic [CAP_W-1:0]      i_cap_index  = '0;
    logic [TIME_W-1:0]     i_now_sec    = '0;
    logic                  i_time_valid = 1'b0;
    logic                  o_done;
    logic                  o_suppress;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    dedup_scoreboard sb;
    bit [ID_W-1:0]   pid_pool [NUM_PIDS];
    bit [TIME_W-1:0] time_cursor;
    int              cur_window;
    int              idle_cycles;

    pid_event_dedup_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_proc_id    (i_proc_id),
        .i_cap_index  (i_cap_index),
        .i_now_sec    (i_now_sec),
        .i_time_valid (i_time_valid),
        .o_done       (o_done),
        .o_suppress   (o_suppress),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Results are checked before the new event is noted, since a result beat
    // always belongs to an event accepted earlier.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                sb.check_suppress(o_suppress);
            end
            if (start && !busy) begin
                sb.note_event(i_proc_id, i_cap_index, i_now_sec, i_time_valid);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((start && !busy) || o_done) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("pid_event_dedup_filter test failed");
                $finish;
            end
        end
    end

    task automatic send_event(bit [ID_W-1:0] pid, bit [CAP_W-1:0] cap,
                              bit [TIME_W-1:0] now, bit tv);
        start        <= 1'b1;
        i_proc_id    <= pid;
        i_cap_index  <= cap;
        i_now_sec    <= now;
        i_time_valid <= tv;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic sender_gap(int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Hold off the sender until every owed result beat has come back.
    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.expected_suppress.size() != 0);
    endtask

    task automatic write_config(int window, bit enable);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WINDOW;
        i_cfg_data <= CFG_DATA_W'(window);
        @(posedge i_clk);
        sb.set_register(REG_WINDOW, CFG_DATA_W'(window));
        i_cfg_idx  <= REG_ENABLE;
        i_cfg_data <= CFG_DATA_W'(enable);
        @(posedge i_clk);
        sb.set_register(REG_ENABLE, CFG_DATA_W'(enable));
        i_cfg_we   <= 1'b0;
        cur_window = window;
    endtask

    // Hot ids include several that share a bucket, so owners keep trading it.
    task automatic refill_pid_pool();
        pid_pool[0] = '0;
        pid_pool[1] = ID_W'(BUCKET_COUNT);
        pid_pool[2] = $urandom;
        pid_pool[3] = pid_pool[2] + ID_W'(BUCKET_COUNT);
        pid_pool[4] = pid_pool[2] + ID_W'(2 * BUCKET_COUNT);
        pid_pool[5] = '1;
        for (int i = 6; i < NUM_PIDS; i++) begin
            pid_pool[i] = $urandom;
        end
        time_cursor = $urandom;
    endtask

    task automatic send_random_event();
        int              roll;
        int              step;
        bit [ID_W-1:0]   pid;
        bit [CAP_W-1:0]  cap;
        bit [TIME_W-1:0] now;
        bit              tv;
        roll = $urandom_range(99);
        if (roll < 15) begin
            pid = $urandom;
            cap = CAP_W'($urandom_range(255));
            now = $urandom;
            tv  = 1'($urandom_range(1));
        end else begin
            step = $urandom_range(99);
            if (step < 55) begin
                time_cursor += $urandom_range(2);
            end else if (step < 85) begin
                time_cursor += $urandom_range(cur_window);
            end else if (step < 93) begin
                time_cursor += cur_window + $urandom_range(1000);
            end else if (step < 97) begin
                time_cursor -= $urandom_range(5000, 1);
            end else if (step < 99) begin
                time_cursor = '0;
            end else begin
                time_cursor = $urandom;
            end
            pid = pid_pool[$urandom_range(NUM_PIDS - 1)];
            cap = ($urandom_range(3) != 0) ? CAP_W'($urandom_range(7))
                                           : CAP_W'($urandom_range(63));
            if (roll >= 95) begin
                cap = CAP_W'($urandom_range(255, 64));
            end
            now = time_cursor;
            tv  = ($urandom_range(19) != 0);
        end
        send_event(pid, cap, now, tv);
    endtask

    initial begin
        sb = new();
        cur_window = WINDOW_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_config(WINDOW_RESET, 1'b1);

        // Zero start on a fresh bucket hit by id 0 never expires.
        send_event('0, 0, 100, 1'b1);
        send_event('0, 0, 5000, 1'b1);
        // Window straddling the 32-bit wrap, then its exact edge.
        send_event('1, 63, 32'hFFFF_FFF0, 1'b1);
        send_event('1, 63, 32'h0000_0020, 1'b1);
        send_event('1, 63, 32'h0000_002B, 1'b1);
        send_event('1, 63, 32'h0000_002C, 1'b1);
        // Time going backwards expires the window.
        send_event('1, 63, 32'h0000_0010, 1'b1);
        // Bypass cases leave the bucket alone.
        send_event('1, 64, 32'h0000_0010, 1'b1);
        send_event('1, 255, 32'h0000_0010, 1'b1);
        send_event('1, 63, 32'h0000_0010, 1'b0);
        send_event('1, 63, 32'h0000_0010, 1'b1);
        // A new owner takes the bucket, then the old one takes it back.
        send_event(ID_W'(BUCKET_COUNT), 0, 200, 1'b1);
        send_event('0, 0, 200, 1'b1);
        // Rebound at time zero, so the window never ends.
        send_event(5, 1, '0, 1'b1);
        send_event(5, 1, 32'h8000_0000, 1'b1);
        send_event(5, 32, 32'h8000_0000, 1'b1);
        wait_all_results();

        write_config(WINDOW_RESET, 1'b0);
        send_event(5, 1, 32'h8000_0000, 1'b1);
        wait_all_results();

        // Zero window: any bucket with a nonzero start is rebound every time.
        write_config(0, 1'b1);
        send_event('1, 63, 32'h0000_0100, 1'b1);
        send_event('1, 63, 32'h0000_0100, 1'b1);
        send_event(5, 1, 1, 1'b1);
        wait_all_results();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_config(PH_WINDOW[ph], PH_ENABLE[ph][0]);
            refill_pid_pool();
            for (int n = 0; n < PH_ITEMS[ph]; n++) begin
                send_random_event();
                if (n == PH_ITEMS[ph] / 2) begin
                    wait_all_results();
                end else begin
                    sender_gap(PH_IDLE[ph]);
                end
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_suppress.size() != 0) begin
            sb.report_mismatch($sformatf("%0d result beats never arrived",
                                         sb.expected_suppress.size()));
        end
        if (sb.mismatch_count == 0) begin
            $display("pid_event_dedup_filter test passed");
        end else begin
            $display("pid_event_dedup_filter test failed");
        end
        $finish;
    end

endmodule

// ===== pid_event_dedup_filter.f =====
+incdir+src
src/pedf_pkg.sv
src/pedf_bucket_ram.sv
src/pedf_bucket_upd.sv
src/pid_event_dedup_filter.sv
src/pedf_checker.sv
sim/tb_pid_event_dedup_filter.sv
